FILE: hw/rtl/add_on_descriptor_parser_defines.svh
// Shared assertion macros for the descriptor parser.
`ifndef ADD_ON_DESCRIPTOR_PARSER_DEFINES_SVH
`define ADD_ON_DESCRIPTOR_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ADP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("descriptor parser assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ADP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("descriptor parser assertion failed");

`endif

FILE: hw/rtl/adp_pkg.sv
`default_nettype none

package adp_pkg;

  // Parse phases, one-hot
  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_MAGIC     = 10'b00_0000_0010,
    PH_NAME_LEN  = 10'b00_0000_0100,
    PH_NAME      = 10'b00_0000_1000,
    PH_DNAME_LEN = 10'b00_0001_0000,
    PH_DNAME     = 10'b00_0010_0000,
    PH_DATA_LEN  = 10'b00_0100_0000,
    PH_DATA      = 10'b00_1000_0000,
    PH_COUNT     = 10'b01_0000_0000,
    PH_DONE      = 10'b10_0000_0000
  } phase_e;

  // Byte classification codes
  localparam logic [3:0] KIND_MAGIC      = 4'd0;
  localparam logic [3:0] KIND_NAME_LEN   = 4'd1;
  localparam logic [3:0] KIND_NAME_CHAR  = 4'd2;
  localparam logic [3:0] KIND_DNAME_LEN  = 4'd3;
  localparam logic [3:0] KIND_DNAME_CHAR = 4'd4;
  localparam logic [3:0] KIND_DATA_LEN   = 4'd5;
  localparam logic [3:0] KIND_DATA_BYTE  = 4'd6;
  localparam logic [3:0] KIND_COUNT      = 4'd7;
  localparam logic [3:0] KIND_IGNORED    = 4'd8;

  // Parse status codes
  localparam logic [1:0] STAT_BUSY      = 2'd0;
  localparam logic [1:0] STAT_VALID     = 2'd1;
  localparam logic [1:0] STAT_BAD_MAGIC = 2'd2;
  localparam logic [1:0] STAT_READ_FAIL = 2'd3;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] drv;
    logic [7:0] remaining;
    logic [7:0] position;
    logic [2:0] extras;
    logic [1:0] status;
  } adp_state_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] driver;
    logic [7:0] position;
    logic       keep;
    logic [7:0] stored_value;
    logic [1:0] status;
  } adp_result_t;

  // Expected magic byte per position; position zero matches anything
  function automatic logic [7:0] magic_expect(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd1:    val = 8'h49;
      2'd2:    val = 8'h46;
      2'd3:    val = 8'h45;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/adp_step.sv
`default_nettype none

module adp_step #(
  parameter int unsigned MAX_NAME_LEN        = 32,
  parameter int unsigned MAX_DRIVER_NAME_LEN = 32,
  parameter int unsigned MAX_DRIVER_DATA_LEN = 32,
  parameter int unsigned MAX_EXTRA_DRIVERS   = 4
) (
  input  adp_pkg::adp_state_t  state_i,
  input  logic                 start_req_i,
  input  logic [7:0]           byte_in_i,
  input  logic                 read_failed_i,
  output adp_pkg::adp_state_t  state_o,
  output adp_pkg::adp_result_t result_o
);
  import adp_pkg::*;

  localparam logic [7:0] NameLim  = 8'(MAX_NAME_LEN);
  localparam logic [7:0] DNameLim = 8'(MAX_DRIVER_NAME_LEN);
  localparam logic [7:0] DataLim  = 8'(MAX_DRIVER_DATA_LEN);
  localparam logic [7:0] ExtraLim = 8'(MAX_EXTRA_DRIVERS);

  adp_state_t  st;
  adp_result_t res;
  logic        field_end;
  phase_e      cur_ph;
  logic [7:0]  lim;
  logic [7:0]  clamped;
  logic [1:0]  mpos;

  always_comb begin
    st        = state_i;
    res       = '0;
    res.kind  = KIND_IGNORED;
    field_end = 1'b0;
    lim       = NameLim;
    clamped   = 8'd0;
    mpos      = 2'd0;

    // Restart on a start marker, whatever the current phase
    if (start_req_i) begin
      st.phase    = PH_MAGIC;
      st.drv      = 3'd0;
      st.remaining = 8'd0;
      st.position = 8'd0;
      st.extras   = 3'd0;
      st.status   = STAT_BUSY;
    end
    cur_ph = st.phase;

    // Field limit of the current phase
    case (cur_ph)
      PH_DNAME_LEN, PH_DNAME: lim = DNameLim;
      PH_DATA_LEN, PH_DATA:   lim = DataLim;
      PH_COUNT:               lim = ExtraLim;
      default:                lim = NameLim;
    endcase
    clamped = (byte_in_i > lim) ? lim : byte_in_i;

    case (cur_ph)
      PH_MAGIC: begin
        mpos             = st.position[1:0];
        res.kind         = KIND_MAGIC;
        res.driver       = st.drv;
        res.position     = {6'd0, mpos};
        res.stored_value = byte_in_i;
        if (read_failed_i) begin
          st.status = STAT_READ_FAIL;
          st.phase  = PH_DONE;
        end else begin
          // Remaining doubles as the mismatch flag during the magic
          if (mpos != 2'd0 && byte_in_i != magic_expect(mpos)) begin
            st.remaining = 8'd1;
          end
          if (mpos == 2'd3) begin
            if (st.remaining != 8'd0) begin
              st.status = STAT_BAD_MAGIC;
              st.phase  = PH_DONE;
            end else begin
              st.phase     = PH_NAME_LEN;
              st.position  = 8'd0;
              st.remaining = 8'd0;
            end
          end else begin
            st.position = {6'd0, mpos + 2'd1};
          end
        end
      end
      PH_NAME_LEN, PH_DNAME_LEN, PH_DATA_LEN: begin
        res.kind = (cur_ph == PH_NAME_LEN)  ? KIND_NAME_LEN :
                   (cur_ph == PH_DNAME_LEN) ? KIND_DNAME_LEN : KIND_DATA_LEN;
        res.driver       = st.drv;
        res.stored_value = clamped;
        if (read_failed_i) begin
          st.status = (st.drv == 3'd0) ? STAT_READ_FAIL : STAT_VALID;
          st.phase  = PH_DONE;
        end else begin
          res.keep = 1'b1;
          if (byte_in_i == 8'd0) begin
            field_end = 1'b1;
          end else begin
            st.phase     = (cur_ph == PH_NAME_LEN)  ? PH_NAME :
                           (cur_ph == PH_DNAME_LEN) ? PH_DNAME : PH_DATA;
            st.remaining = byte_in_i;
            st.position  = 8'd0;
          end
        end
      end
      PH_NAME, PH_DNAME, PH_DATA: begin
        res.kind = (cur_ph == PH_NAME)  ? KIND_NAME_CHAR :
                   (cur_ph == PH_DNAME) ? KIND_DNAME_CHAR : KIND_DATA_BYTE;
        res.driver       = st.drv;
        res.position     = st.position;
        res.stored_value = byte_in_i;
        if (read_failed_i) begin
          st.status = (st.drv == 3'd0) ? STAT_READ_FAIL : STAT_VALID;
          st.phase  = PH_DONE;
        end else begin
          res.keep     = (st.position < lim);
          st.position  = st.position + 8'd1;
          st.remaining = st.remaining - 8'd1;
          field_end    = (st.remaining == 8'd0);
        end
      end
      PH_COUNT: begin
        res.kind         = KIND_COUNT;
        res.driver       = st.drv;
        res.stored_value = clamped;
        if (read_failed_i) begin
          st.status = STAT_READ_FAIL;
          st.phase  = PH_DONE;
        end else begin
          res.keep  = 1'b1;
          st.extras = clamped[2:0];
          if (clamped[2:0] == 3'd0) begin
            st.status = STAT_VALID;
            st.phase  = PH_DONE;
          end else begin
            st.drv   = 3'd1;
            st.phase = PH_DNAME_LEN;
          end
        end
      end
      default: begin
        // Idle or finished: the byte is ignored
      end
    endcase

    // Advance to the next field once the current one ends, or finish after the last driver
    if (field_end) begin
      if (cur_ph == PH_NAME_LEN || cur_ph == PH_NAME) begin
        st.phase = PH_DNAME_LEN;
      end else if (cur_ph == PH_DNAME_LEN || cur_ph == PH_DNAME) begin
        st.phase = PH_DATA_LEN;
      end else if (st.drv == 3'd0) begin
        st.phase = PH_COUNT;
      end else if (st.drv >= st.extras) begin
        st.status = STAT_VALID;
        st.phase  = PH_DONE;
      end else begin
        st.drv   = st.drv + 3'd1;
        st.phase = PH_DNAME_LEN;
      end
    end

    res.status = st.status;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

`default_nettype wire

FILE: hw/rtl/add_on_descriptor_parser.sv
// Add-on descriptor parser.
// Input channel (in_valid_i / in_ready_o): one descriptor byte per transaction,
// with start_req_i marking offset zero and read_failed_i flagging a bad read.
// Output channel (out_valid_o / out_ready_i): exactly one classification per
// input byte, in order: field kind, driver index, position in field, keep
// flag, stored value (clamped for length and count bytes) and parse status.
// Path: a byte accepted into the input register is parsed by the next-state
// logic and lands in the output register, which raises out_valid_o; the
// result is held there until the receiver takes it.
// Throughput: one byte per cycle unless the receiver stalls; the parse state
// updates in the single pass between the input and output registers.
// Reset: both registers empty, parse idle, status zero; bytes arriving before
// a start marker are reported as ignored.
// Receiver stall: the output register holds its result; the input register
// takes one more byte, then in_ready_o drops until the output drains.
`default_nettype none
`include "add_on_descriptor_parser_defines.svh"

module add_on_descriptor_parser #(
  parameter int unsigned MAX_NAME_LEN        = 32,
  parameter int unsigned MAX_DRIVER_NAME_LEN = 32,
  parameter int unsigned MAX_DRIVER_DATA_LEN = 32,
  parameter int unsigned MAX_EXTRA_DRIVERS   = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_req_i,
  input  logic [7:0] byte_in_i,
  input  logic       read_failed_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] kind_o,
  output logic [2:0] driver_o,
  output logic [7:0] position_o,
  output logic       keep_o,
  output logic [7:0] stored_value_o,
  output logic [1:0] status_o
);
  import adp_pkg::*;

  logic        in_valid_q;
  logic        in_start_q;
  logic [7:0]  in_byte_q;
  logic        in_fail_q;
  logic        out_valid_q;
  adp_result_t out_q;
  adp_state_t  state_q, state_d;
  adp_result_t result_d;
  logic        out_free;
  logic        advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_start_q <= start_req_i;
      in_byte_q  <= byte_in_i;
      in_fail_q  <= read_failed_i;
    end
  end

  adp_step #(
    .MAX_NAME_LEN       (MAX_NAME_LEN),
    .MAX_DRIVER_NAME_LEN(MAX_DRIVER_NAME_LEN),
    .MAX_DRIVER_DATA_LEN(MAX_DRIVER_DATA_LEN),
    .MAX_EXTRA_DRIVERS  (MAX_EXTRA_DRIVERS)
  ) u_step (
    .state_i      (state_q),
    .start_req_i  (in_start_q),
    .byte_in_i    (in_byte_q),
    .read_failed_i(in_fail_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // Advance the parse state once per byte moved to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, drv: 3'd0, remaining: 8'd0, position: 8'd0,
                   extras: 3'd0, status: STAT_BUSY};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign driver_o       = out_q.driver;
  assign position_o     = out_q.position;
  assign keep_o         = out_q.keep;
  assign stored_value_o = out_q.stored_value;
  assign status_o       = out_q.status;

  `ADP_ASSERT_NOW(a_ready_when_out_empty, clk_i, rst_ni, !out_valid_q, in_ready_o)
  `ADP_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `ADP_ASSERT_NOW(a_kept_not_failed, clk_i, rst_ni, out_valid_q && out_q.keep,
                  out_q.status == STAT_BUSY || out_q.status == STAT_VALID)
  `ADP_ASSERT_NOW(a_magic_not_kept, clk_i, rst_ni,
                  out_valid_q && out_q.kind == KIND_MAGIC,
                  !out_q.keep && out_q.driver == 3'd0)

endmodule

`default_nettype wire
